FILE: hdl/sde_pkg.sv
// shared types and operation codes for the symmetric difference engine
// no dependencies
package sde_pkg;

  localparam logic [1:0] OP_APPEND_A = 2'd0;
  localparam logic [1:0] OP_APPEND_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               from_b;
    logic               last;
    logic               empty_res;
    logic               overflow;
  } out_item_t;

endpackage

FILE: hdl/symmetric_difference_engine_top.sv
// top level of the symmetric difference engine: sequencer, counters and output register
// depends on sde_pkg and sde_ram
//
// Append transfers are accepted back to back; an append into a full set is dropped and
// sets a sticky overflow flag. A compute transfer holds the input stalled while one
// shared equality comparator walks the stores: each stored element of A, then of B, is
// fetched, checked against the elements of the other set one at a time (the scan stops
// at the first match) and then decided, so the input stays stalled until the walk and
// the final result are done, and longer while the output is stalled. The single read
// port of each set store sets the pace of the walk.
// Results come out in stored order, A first, with last on the final one, or one result
// with empty_res set when nothing differs.
module symmetric_difference_engine_top
  import sde_pkg::*;
#(
  parameter int SET_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SET_DEPTH);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_OUTER_RD = 3'd1;
  localparam logic [2:0] S_OUTER_LT = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_DECIDE   = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic               phase_r, phase_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [31:0]        elem_r, elem_nxt;
  logic               found_r, found_nxt;
  logic [31:0]        pend_r, pend_nxt;
  logic               pend_b_r, pend_b_nxt;
  logic               have_pend_r, have_pend_nxt;
  logic [CNT_W-1:0]   count_a_r, count_a_nxt;
  logic [CNT_W-1:0]   count_b_r, count_b_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               in_xfer;
  logic               out_free;
  logic [CNT_W-1:0]   i_inc, j_inc, cnt_outer, cnt_inner, inner_addr;
  logic               we_a, we_b;
  logic [IDX_W-1:0]   raddr_a, raddr_b;
  logic [31:0]        rdata_a, rdata_b, outer_data, inner_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign i_inc      = i_r + 1'b1;
  assign j_inc      = j_r + 1'b1;
  assign cnt_outer  = phase_r ? count_b_r : count_a_r;
  assign cnt_inner  = phase_r ? count_a_r : count_b_r;
  assign inner_addr = (state_r == S_SCAN) ? j_inc : '0;
  assign raddr_a    = phase_r ? inner_addr[IDX_W-1:0] : i_r[IDX_W-1:0];
  assign raddr_b    = phase_r ? i_r[IDX_W-1:0] : inner_addr[IDX_W-1:0];
  assign outer_data = phase_r ? rdata_b : rdata_a;
  assign inner_data = phase_r ? rdata_a : rdata_b;

  assign we_a = in_xfer && (in_data.operation == OP_APPEND_A) && (count_a_r < DEPTH_C);
  assign we_b = in_xfer && (in_data.operation == OP_APPEND_B) && (count_b_r < DEPTH_C);

  sde_ram #(.WIDTH(32), .DEPTH(SET_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a_r[IDX_W-1:0]),
    .wdata (in_data.value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  sde_ram #(.WIDTH(32), .DEPTH(SET_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b_r[IDX_W-1:0]),
    .wdata (in_data.value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    elem_nxt      = elem_r;
    found_nxt     = found_r;
    pend_nxt      = pend_r;
    pend_b_nxt    = pend_b_r;
    have_pend_nxt = have_pend_r;
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data.operation)
            OP_APPEND_A: begin
              if (count_a_r < DEPTH_C) begin
                count_a_nxt = count_a_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_APPEND_B: begin
              if (count_b_r < DEPTH_C) begin
                count_b_nxt = count_b_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_COMPUTE: begin
              i_nxt         = '0;
              have_pend_nxt = 1'b0;
              phase_nxt     = 1'b0;
              state_nxt     = S_OUTER_RD;
              if (count_a_r == '0) begin
                phase_nxt = 1'b1;
                if (count_b_r == '0) begin
                  state_nxt = S_FINISH;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_OUTER_RD: begin
        state_nxt = S_OUTER_LT;
      end
      S_OUTER_LT: begin
        elem_nxt = outer_data;
        j_nxt    = '0;
        if (cnt_inner == '0) begin
          found_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (inner_data == elem_r) begin
          found_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end else if (j_inc == cnt_inner) begin
          found_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          j_nxt = j_inc;
        end
      end
      S_DECIDE: begin
        if (found_r || !have_pend_r || out_free) begin
          if (!found_r) begin
            if (have_pend_r) begin
              out_valid_nxt          = 1'b1;
              out_data_nxt.value_res = pend_r;
              out_data_nxt.from_b    = pend_b_r;
              out_data_nxt.last      = 1'b0;
              out_data_nxt.empty_res = 1'b0;
              out_data_nxt.overflow  = ovf_r;
            end
            pend_nxt      = elem_r;
            pend_b_nxt    = phase_r;
            have_pend_nxt = 1'b1;
          end
          if (i_inc == cnt_outer) begin
            if (!phase_r && (count_b_r != '0)) begin
              phase_nxt = 1'b1;
              i_nxt     = '0;
              state_nxt = S_OUTER_RD;
            end else begin
              state_nxt = S_FINISH;
            end
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_OUTER_RD;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.value_res = have_pend_r ? pend_r : '0;
          out_data_nxt.from_b    = have_pend_r ? pend_b_r : 1'b0;
          out_data_nxt.last      = 1'b1;
          out_data_nxt.empty_res = !have_pend_r;
          out_data_nxt.overflow  = ovf_r;
          count_a_nxt            = '0;
          count_b_nxt            = '0;
          ovf_nxt                = 1'b0;
          have_pend_nxt          = 1'b0;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      have_pend_r <= 1'b0;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      have_pend_r <= have_pend_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    elem_r     <= elem_nxt;
    found_r    <= found_nxt;
    pend_r     <= pend_nxt;
    pend_b_r   <= pend_b_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: hdl/sde_ram.sv
// generic single write port ram with registered read
// no dependencies
module sde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: test/tb_symmetric_difference_engine_top.sv
// self-checking testbench for symmetric_difference_engine_top: random set loads and computes
// with random valid/stall gaps, results checked in order against a built-in set tracker
// depends on sde_pkg and the engine rtl
module tb_symmetric_difference_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sde_pkg::*;

  localparam int SET_DEPTH = 16;
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int RANDOM_ITEMS = 250;
  localparam int DRAIN_CYCLES = 2 * SET_DEPTH * (SET_DEPTH + 2) + 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;

  class symdiff_tracker;
    int depth;
    logic signed [31:0] set_a[$];
    logic signed [31:0] set_b[$];
    bit overflow_seen;
    out_item_t pending_results[$];
    int failures;
    int computes;
    int empties;
    int overflow_runs;
    int checked;

    function new(int set_depth);
      depth = set_depth;
    endfunction

    function bit found_in(logic signed [31:0] store[$], logic signed [31:0] v);
      foreach (store[i]) begin
        if (store[i] == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void predict_difference();
      out_item_t run[$];
      out_item_t r;
      foreach (set_a[i]) begin
        if (!found_in(set_b, set_a[i])) begin
          r = '0;
          r.value_res = set_a[i];
          r.overflow = overflow_seen;
          run.push_back(r);
        end
      end
      foreach (set_b[i]) begin
        if (!found_in(set_a, set_b[i])) begin
          r = '0;
          r.value_res = set_b[i];
          r.from_b = 1'b1;
          r.overflow = overflow_seen;
          run.push_back(r);
        end
      end
      if (run.size() == 0) begin
        r = '0;
        r.empty_res = 1'b1;
        r.overflow = overflow_seen;
        run.push_back(r);
        empties++;
      end
      run[run.size() - 1].last = 1'b1;
      if (overflow_seen) overflow_runs++;
      computes++;
      foreach (run[i]) pending_results.push_back(run[i]);
      set_a.delete();
      set_b.delete();
      overflow_seen = 1'b0;
    endfunction

    function void absorb_transfer(in_item_t it);
      case (it.operation)
        OP_APPEND_A: begin
          if (set_a.size() < depth) set_a.push_back(it.value);
          else overflow_seen = 1'b1;
        end
        OP_APPEND_B: begin
          if (set_b.size() < depth) set_b.push_back(it.value);
          else overflow_seen = 1'b1;
        end
        OP_COMPUTE: begin
          predict_difference();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: value_res %0d from_b %0b", got.value_res,
               got.from_b);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.value_res !== want.value_res) begin
        $error("value_res: expected %0d, got %0d", want.value_res, got.value_res);
        failures++;
      end
      if (got.from_b !== want.from_b) begin
        $error("from_b: expected %0b, got %0b", want.from_b, got.from_b);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
        failures++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
        failures++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  symdiff_tracker tracker;
  int  sent;
  bit  send_calm;
  bit  hold_off_done;

  symmetric_difference_engine_top #(
    .SET_DEPTH(SET_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_item(input logic [1:0] op, input logic signed [31:0] val);
    in_item_t it;
    int gap;
    it.operation = op;
    it.value = val;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    tracker.absorb_transfer(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic random_batch();
    logic signed [31:0] pool[4];
    int n_a;
    int n_b;
    int left_a;
    int left_b;
    logic signed [31:0] v;
    n_a = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
    n_b = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
    foreach (pool[i]) pool[i] = $urandom;
    send_calm = ($urandom_range(0, 3) == 0);
    left_a = n_a;
    left_b = n_b;
    while (left_a + left_b > 0) begin
      if ($urandom_range(0, 11) == 0) push_item(OP_IGNORED, $urandom);
      v = $urandom_range(0, 2) != 0 ? pool[$urandom_range(0, 3)] : $urandom;
      if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 0)) begin
        push_item(OP_APPEND_A, v);
        left_a--;
      end else begin
        push_item(OP_APPEND_B, v);
        left_b--;
      end
    end
    push_item(OP_COMPUTE, $urandom);
  endtask

  // sender
  initial begin
    tracker = new(SET_DEPTH);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sent = 0;
    send_calm = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // both sets empty
    push_item(OP_COMPUTE, 32'sd0);
    // duplicates cancel out completely
    push_item(OP_APPEND_A, -32'sd1);
    push_item(OP_APPEND_A, -32'sd1);
    push_item(OP_APPEND_B, -32'sd1);
    push_item(OP_COMPUTE, -32'sd1);
    // extremes, an ignored opcode, and a full set b with one dropped append
    push_item(OP_APPEND_A, 32'sh7fff_ffff);
    push_item(OP_APPEND_A, 32'sh8000_0000);
    push_item(OP_IGNORED, 32'sh5a5a_a5a5);
    push_item(OP_APPEND_B, 32'sh8000_0000);
    push_item(OP_APPEND_B, 32'sd0);
    repeat (SET_DEPTH - 1) push_item(OP_APPEND_B, $urandom);
    push_item(OP_COMPUTE, 32'sh7fff_ffff);

    while (sent < RANDOM_ITEMS + 26) random_batch();
    in_valid = 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending_results.size() != 0) begin
      $error("%0d results never arrived", tracker.pending_results.size());
      tracker.failures++;
    end
    $display("%0d transfers in, %0d results checked over %0d computes", sent,
             tracker.checked, tracker.computes);
    $display("%0d empty differences, %0d runs with a dropped append", tracker.empties,
             tracker.overflow_runs);
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int stall_left;
    int calm_left;
    out_stall = 1'b0;
    stall_left = 0;
    calm_left = 0;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_off_done && tracker != null && tracker.checked >= 20) begin
        hold_off_done = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 7) == 0) begin
          calm_left = $urandom_range(20, 80);
        end else begin
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // watchdog on transfer activity
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles with no transfer", idle);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
